// ===== rtl/cts_pkg.sv =====
// Shared types and constants for the cooker thermostat sequencer.
// Used by cts_minutes, cts_ctrl and cooker_thermostat_sequencer; no dependencies.
package cts_pkg;

    localparam int unsigned TempW    = 10;
    localparam int unsigned TickW    = 12;
    localparam int unsigned OffsetW  = 4;
    localparam int unsigned MinutesW = 9;
    localparam int unsigned PhaseW   = 3;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 12;

    // Operation codes on the input channel.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;
    localparam logic [1:0] OP_STOP   = 2'd3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_COOK_TICKS   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_FOOD_TARGET  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_WATER_OFFSET = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_HEATER_LIMIT = 2'd3;

    // Register reset values.
    localparam logic [TickW-1:0]   COOK_TICKS_RST   = 12'd120;
    localparam logic [TempW-1:0]   FOOD_TARGET_RST  = 10'd65;
    localparam logic [OffsetW-1:0] WATER_OFFSET_RST = 4'd0;
    localparam logic [TempW-1:0]   HEATER_LIMIT_RST = 10'd200;

    localparam logic [TickW-1:0] TICK_MAX = 12'd4095;

    // One tick is five seconds, so minutes are ticks / 12 = (ticks >> 2) / 3.
    // x / 3 equals (x * 683) >> 11 for every x below 2048.
    localparam logic [9:0] DIV3_MAGIC = 10'd683;
    localparam int unsigned DIV3_SHIFT = 11;

    // Phase codes as they appear on the result channel.
    localparam logic [PhaseW-1:0] PHASE_IDLE    = 3'd0;
    localparam logic [PhaseW-1:0] PHASE_MAIN    = 3'd1;
    localparam logic [PhaseW-1:0] PHASE_WATER   = 3'd2;
    localparam logic [PhaseW-1:0] PHASE_HEATER  = 3'd3;
    localparam logic [PhaseW-1:0] PHASE_CONFIRM = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_MAIN    = 5'b00010,
        ST_WATER   = 5'b00100,
        ST_HEATER  = 5'b01000,
        ST_CONFIRM = 5'b10000
    } state_t;

    typedef struct packed {
        logic [TickW-1:0]   cook_ticks;
        logic [TempW-1:0]   food_target;
        logic [OffsetW-1:0] first_water_offset;
        logic [TempW-1:0]   first_heater_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic [TempW-1:0] water_temp;
        logic [TempW-1:0] heater_temp;
        logic [TempW-1:0] food_temp;
    } item_t;

    typedef struct packed {
        logic                heater_on;
        logic [PhaseW-1:0]   phase;
        logic                food_reached;
        logic [MinutesW-1:0] minutes_left;
        logic                cooked;
    } result_t;

endpackage

// ===== rtl/cts_minutes.sv =====
// Minutes-left calculation from the remaining cook ticks.
// Depends on cts_pkg.
module cts_minutes
    import cts_pkg::*;
(
    input  logic                confirmed,
    input  logic [TickW-1:0]    cook_ticks,
    input  logic [TickW-1:0]    elapsed,
    output logic [MinutesW-1:0] minutes
);

    logic [TickW-1:0]  remain;
    logic [19:0]       product;
    logic [MinutesW-1:0] quotient;

    always_comb
    begin
        remain   = (cook_ticks > elapsed) ? cook_ticks - elapsed : '0;
        product  = remain[TickW-1:2] * DIV3_MAGIC;
        quotient = product[DIV3_SHIFT +: MinutesW];
        minutes  = confirmed ? quotient + MinutesW'(1) : '0;
    end

endmodule

// ===== rtl/cts_ctrl.sv =====
// Sequencer state and next-state logic for one item per enabled cycle.
// Depends on cts_pkg and cts_minutes.
module cts_ctrl
    import cts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    state_t           state_reg, state_next;
    logic             heater_reg, heater_next;
    logic             first_done_reg, first_done_next;
    logic             confirmed_reg, confirmed_next;
    logic             return_hold_reg, return_hold_next;
    logic [TickW-1:0] elapsed_reg, elapsed_next;
    logic [TempW-1:0] water_limit_reg, water_limit_next;
    logic [TempW-1:0] heater_limit_reg, heater_limit_next;

    logic clear_run, start_run, heat_on, check_end, cooked;
    logic running, water_hit, heater_hit, food_hit, time_left;

    assign running    = (state_reg != ST_IDLE);
    assign water_hit  = (item.water_temp >= water_limit_reg);
    assign heater_hit = (item.heater_temp >= heater_limit_reg);
    assign food_hit   = (item.food_temp >= cfg.food_target);
    assign time_left  = (elapsed_reg < cfg.cook_ticks);

    always_comb
    begin
        state_next        = state_reg;
        heater_next       = heater_reg;
        first_done_next   = first_done_reg;
        confirmed_next    = confirmed_reg;
        return_hold_next  = return_hold_reg;
        elapsed_next      = elapsed_reg;
        water_limit_next  = water_limit_reg;
        heater_limit_next = heater_limit_reg;
        clear_run = 1'b0;
        start_run = 1'b0;
        heat_on   = 1'b0;
        check_end = 1'b0;
        cooked    = 1'b0;

        unique case (item.operation)
            OP_STOP:
            begin
                clear_run = 1'b1;
            end
            OP_START:
            begin
                if (!running)
                begin
                    clear_run = 1'b1;
                    start_run = 1'b1;
                    heat_on   = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (running && confirmed_reg && elapsed_reg < TICK_MAX)
                begin
                    elapsed_next = elapsed_reg + TickW'(1);
                end
            end
            default:
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                    end
                    ST_MAIN:
                    begin
                        if (water_hit)
                        begin
                            heater_next = 1'b0;
                            state_next  = ST_WATER;
                        end
                        else if (food_hit)
                        begin
                            heater_next = 1'b0;
                            if (!confirmed_reg)
                                state_next = ST_CONFIRM;
                            else
                                check_end = 1'b1;
                        end
                        else if (heater_hit)
                        begin
                            heater_next = 1'b0;
                            state_next  = ST_HEATER;
                        end
                        else
                        begin
                            check_end = 1'b1;
                        end
                    end
                    ST_WATER:
                    begin
                        if (food_hit && !confirmed_reg)
                        begin
                            heater_next = 1'b0;
                            state_next  = ST_CONFIRM;
                        end
                        else if (water_hit && time_left)
                        begin
                            // Keep holding with the heater off.
                        end
                        else if (return_hold_reg)
                        begin
                            return_hold_next = 1'b0;
                            heater_next      = 1'b0;
                            state_next       = ST_HEATER;
                        end
                        else
                        begin
                            heat_on   = 1'b1;
                            check_end = 1'b1;
                        end
                    end
                    ST_HEATER:
                    begin
                        if (food_hit)
                        begin
                            heater_next = 1'b0;
                            if (!confirmed_reg)
                                state_next = ST_CONFIRM;
                            else
                                check_end = 1'b1;
                        end
                        else if (water_hit)
                        begin
                            return_hold_next = 1'b1;
                            heater_next      = 1'b0;
                            state_next       = ST_WATER;
                        end
                        else if (heater_hit && time_left)
                        begin
                            // Keep holding with the heater off.
                        end
                        else
                        begin
                            heat_on   = 1'b1;
                            check_end = 1'b1;
                        end
                    end
                    ST_CONFIRM:
                    begin
                        if (food_hit)
                            confirmed_next = 1'b1;
                        else
                            heat_on = 1'b1;
                        check_end = 1'b1;
                    end
                    default:
                    begin
                        clear_run = 1'b1;
                    end
                endcase
            end
        endcase

        // The actions below run in the order the sequencer applies them.
        if (clear_run)
        begin
            state_next       = ST_IDLE;
            heater_next      = 1'b0;
            first_done_next  = 1'b0;
            confirmed_next   = 1'b0;
            elapsed_next     = '0;
            return_hold_next = 1'b0;
        end
        if (start_run)
        begin
            state_next = ST_MAIN;
        end
        if (heat_on)
        begin
            heater_next = 1'b1;
            if (!first_done_next)
            begin
                heater_limit_next = cfg.first_heater_limit;
                water_limit_next  = (cfg.food_target > TempW'(cfg.first_water_offset)) ?
                                    cfg.food_target - TempW'(cfg.first_water_offset) : '0;
                first_done_next   = 1'b1;
            end
            else
            begin
                heater_limit_next = cfg.food_target;
                water_limit_next  = (cfg.food_target != '0) ?
                                    cfg.food_target - TempW'(1) : '0;
            end
        end
        if (check_end)
        begin
            if (!time_left)
            begin
                state_next       = ST_IDLE;
                heater_next      = 1'b0;
                first_done_next  = 1'b0;
                confirmed_next   = 1'b0;
                elapsed_next     = '0;
                return_hold_next = 1'b0;
                cooked           = 1'b1;
            end
            else
            begin
                state_next = ST_MAIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            heater_reg       <= 1'b0;
            first_done_reg   <= 1'b0;
            confirmed_reg    <= 1'b0;
            return_hold_reg  <= 1'b0;
            elapsed_reg      <= '0;
            water_limit_reg  <= '0;
            heater_limit_reg <= '0;
        end
        else if (step)
        begin
            state_reg        <= state_next;
            heater_reg       <= heater_next;
            first_done_reg   <= first_done_next;
            confirmed_reg    <= confirmed_next;
            return_hold_reg  <= return_hold_next;
            elapsed_reg      <= elapsed_next;
            water_limit_reg  <= water_limit_next;
            heater_limit_reg <= heater_limit_next;
        end
    end

    cts_minutes u_minutes (
        .confirmed  (confirmed_next),
        .cook_ticks (cfg.cook_ticks),
        .elapsed    (elapsed_next),
        .minutes    (result.minutes_left)
    );

    always_comb
    begin
        result.heater_on    = heater_next;
        result.food_reached = confirmed_next;
        result.cooked       = cooked;
        unique case (state_next)
            ST_IDLE:    result.phase = PHASE_IDLE;
            ST_MAIN:    result.phase = PHASE_MAIN;
            ST_WATER:   result.phase = PHASE_WATER;
            ST_HEATER:  result.phase = PHASE_HEATER;
            ST_CONFIRM: result.phase = PHASE_CONFIRM;
            default:    result.phase = PHASE_IDLE;
        endcase
    end

endmodule

// ===== rtl/cooker_thermostat_sequencer.sv =====
// Slow-cooker heater sequencer: configuration registers, input word register and
// result register around cts_ctrl. Depends on cts_pkg, cts_ctrl and cts_minutes.
//
// Each input word (sample, tick, start or stop) yields exactly one result word.
// A word is captured in an input register and is evaluated by the sequencer once
// the output register can advance; its result is held in the output register until
// taken. One word can be accepted every cycle while the result side keeps up. The
// sequencer state is updated in the same cycle the result register loads, which is
// what allows back-to-back words. Configuration writes are accepted every cycle and
// should be issued only while no word is in flight.
module cooker_thermostat_sequencer
    import cts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [TempW-1:0]    water_temp,
    input  logic [TempW-1:0]    heater_temp,
    input  logic [TempW-1:0]    food_temp,

    output logic                out_valid,
    input  logic                out_ready,
    output logic                heater_on,
    output logic [PhaseW-1:0]   phase,
    output logic                food_reached,
    output logic [MinutesW-1:0] minutes_left,
    output logic                cooked
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg, result_next;
    logic    out_valid_reg;
    logic    advance;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cook_ticks         <= COOK_TICKS_RST;
            cfg_reg.food_target        <= FOOD_TARGET_RST;
            cfg_reg.first_water_offset <= WATER_OFFSET_RST;
            cfg_reg.first_heater_limit <= HEATER_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COOK_TICKS:   cfg_reg.cook_ticks         <= cfg_data;
                CFG_FOOD_TARGET:  cfg_reg.food_target        <= cfg_data[TempW-1:0];
                CFG_WATER_OFFSET: cfg_reg.first_water_offset <= cfg_data[OffsetW-1:0];
                CFG_HEATER_LIMIT: cfg_reg.first_heater_limit <= cfg_data[TempW-1:0];
                default:          cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.operation   <= operation;
            item_reg.water_temp  <= water_temp;
            item_reg.heater_temp <= heater_temp;
            item_reg.food_temp   <= food_temp;
        end
        if (item_valid_reg && advance)
            result_reg <= result_next;
    end

    cts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (item_valid_reg && advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    assign out_valid    = out_valid_reg;
    assign heater_on    = result_reg.heater_on;
    assign phase        = result_reg.phase;
    assign food_reached = result_reg.food_reached;
    assign minutes_left = result_reg.minutes_left;
    assign cooked       = result_reg.cooked;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for cooker_thermostat_sequencer: a cycle-free model of the
// heater sequencer predicts every result word, which is compared field by field.
// Depends on cts_pkg and the RTL of the block; nothing else.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cts_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 750;
    localparam int HOLD_CYCLES  = 80;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          operation = OP_SAMPLE;
    logic [TempW-1:0]    water_temp = '0;
    logic [TempW-1:0]    heater_temp = '0;
    logic [TempW-1:0]    food_temp = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                heater_on;
    logic [PhaseW-1:0]   phase;
    logic                food_reached;
    logic [MinutesW-1:0] minutes_left;
    logic                cooked;

    // Register copies as the block should hold them.
    logic [TickW-1:0]   cfg_cook_ticks   = COOK_TICKS_RST;
    logic [TempW-1:0]   cfg_food_target  = FOOD_TARGET_RST;
    logic [OffsetW-1:0] cfg_water_offset = WATER_OFFSET_RST;
    logic [TempW-1:0]   cfg_heater_limit = HEATER_LIMIT_RST;

    // Sequencer state as predicted.
    logic [PhaseW-1:0] heat_phase = PHASE_IDLE;
    logic              heater_level = 1'b0;
    logic              first_heating_done = 1'b0;
    logic              food_ok = 1'b0;
    logic              back_to_heater_hold = 1'b0;
    logic [TickW-1:0]  ticks_elapsed = '0;
    logic [TempW-1:0]  water_lim = '0;
    logic [TempW-1:0]  heater_lim = '0;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      idle_pct = 18;
    int      random_words = 0;
    logic    pressure_req = 1'b0;
    logic    pressure_seen = 1'b0;
    int      hold_left = 0;

    cooker_thermostat_sequencer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .water_temp   (water_temp),
        .heater_temp  (heater_temp),
        .food_temp    (food_temp),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .heater_on    (heater_on),
        .phase        (phase),
        .food_reached (food_reached),
        .minutes_left (minutes_left),
        .cooked       (cooked)
    );

    always
    begin
        #5ns clk = ~clk;
    end

    function automatic void heater_start();
        heater_level = 1'b1;
        if (!first_heating_done)
        begin
            heater_lim = cfg_heater_limit;
            water_lim = (cfg_food_target > TempW'(cfg_water_offset)) ?
                        cfg_food_target - TempW'(cfg_water_offset) : '0;
            first_heating_done = 1'b1;
        end
        else
        begin
            heater_lim = cfg_food_target;
            water_lim = (cfg_food_target > 0) ? cfg_food_target - 1'b1 : '0;
        end
    endfunction

    function automatic void clear_run();
        heat_phase = PHASE_IDLE;
        heater_level = 1'b0;
        first_heating_done = 1'b0;
        food_ok = 1'b0;
        ticks_elapsed = '0;
        back_to_heater_hold = 1'b0;
    endfunction

    // Returns 1 when the cook time is used up and the run ends normally.
    function automatic logic cook_time_check();
        if (ticks_elapsed >= cfg_cook_ticks)
        begin
            clear_run();
            return 1'b1;
        end
        heat_phase = PHASE_MAIN;
        return 1'b0;
    endfunction

    function automatic logic food_at_target();
        heater_level = 1'b0;
        if (!food_ok)
        begin
            heat_phase = PHASE_CONFIRM;
            return 1'b0;
        end
        return cook_time_check();
    endfunction

    function automatic result_t next_cooker_result(input logic [1:0] op,
                                                   input logic [TempW-1:0] w,
                                                   input logic [TempW-1:0] h,
                                                   input logic [TempW-1:0] f);
        result_t     r;
        logic        running;
        logic        done;
        int unsigned left;
        running = (heat_phase != PHASE_IDLE);
        done = 1'b0;
        if (op == OP_STOP)
            clear_run();
        else if (op == OP_START)
        begin
            if (!running)
            begin
                clear_run();
                heat_phase = PHASE_MAIN;
                heater_start();
            end
        end
        else if (op == OP_TICK)
        begin
            if (running && food_ok && ticks_elapsed < TICK_MAX)
                ticks_elapsed = ticks_elapsed + 1'b1;
        end
        else if (running)
        begin
            case (heat_phase)
                PHASE_MAIN:
                begin
                    if (w >= water_lim)
                    begin
                        heater_level = 1'b0;
                        heat_phase = PHASE_WATER;
                    end
                    else if (f >= cfg_food_target)
                        done = food_at_target();
                    else if (h >= heater_lim)
                    begin
                        heater_level = 1'b0;
                        heat_phase = PHASE_HEATER;
                    end
                    else
                        done = cook_time_check();
                end
                PHASE_WATER:
                begin
                    if (f >= cfg_food_target && !food_ok)
                    begin
                        heater_level = 1'b0;
                        heat_phase = PHASE_CONFIRM;
                    end
                    else if (w >= water_lim && ticks_elapsed < cfg_cook_ticks)
                    begin
                        // Water still too hot: keep holding.
                    end
                    else if (back_to_heater_hold)
                    begin
                        back_to_heater_hold = 1'b0;
                        heater_level = 1'b0;
                        heat_phase = PHASE_HEATER;
                    end
                    else
                    begin
                        heater_start();
                        done = cook_time_check();
                    end
                end
                PHASE_HEATER:
                begin
                    if (f >= cfg_food_target)
                        done = food_at_target();
                    else if (w >= water_lim)
                    begin
                        back_to_heater_hold = 1'b1;
                        heater_level = 1'b0;
                        heat_phase = PHASE_WATER;
                    end
                    else if (h >= heater_lim && ticks_elapsed < cfg_cook_ticks)
                    begin
                        // Heater still too hot: keep holding.
                    end
                    else
                    begin
                        heater_start();
                        done = cook_time_check();
                    end
                end
                PHASE_CONFIRM:
                begin
                    if (f >= cfg_food_target)
                        food_ok = 1'b1;
                    else
                        heater_start();
                    done = cook_time_check();
                end
                default:
                    clear_run();
            endcase
        end

        r.heater_on = heater_level;
        r.phase = heat_phase;
        r.food_reached = food_ok;
        r.cooked = done;
        r.minutes_left = '0;
        if (food_ok)
        begin
            left = (cfg_cook_ticks > ticks_elapsed) ? cfg_cook_ticks - ticks_elapsed : 0;
            r.minutes_left = MinutesW'(1 + (left * 5) / 60);
        end
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Result side: random stalls, plus one long hold-off when a test asks for it.
    always @(posedge clk)
    begin
        if (pressure_req != pressure_seen)
        begin
            pressure_seen <= pressure_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_error("result word with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                if (heater_on !== want.heater_on)
                    report_error($sformatf("heater_on %b, expected %b",
                                           heater_on, want.heater_on));
                if (phase !== want.phase)
                    report_error($sformatf("phase %0d, expected %0d", phase, want.phase));
                if (food_reached !== want.food_reached)
                    report_error($sformatf("food_reached %b, expected %b",
                                           food_reached, want.food_reached));
                if (minutes_left !== want.minutes_left)
                    report_error($sformatf("minutes_left %0d, expected %0d",
                                           minutes_left, want.minutes_left));
                if (cooked !== want.cooked)
                    report_error($sformatf("cooked %b, expected %b", cooked, want.cooked));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                  input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_COOK_TICKS:   cfg_cook_ticks = data;
            CFG_FOOD_TARGET:  cfg_food_target = data[TempW-1:0];
            CFG_WATER_OFFSET: cfg_water_offset = data[OffsetW-1:0];
            CFG_HEATER_LIMIT: cfg_heater_limit = data[TempW-1:0];
            default: ;
        endcase
    endtask

    // Unused upper data bits carry random values; the block must ignore them.
    task automatic configure(input logic [TickW-1:0] ticks, input logic [TempW-1:0] target,
                             input logic [OffsetW-1:0] offset,
                             input logic [TempW-1:0] hlimit);
        write_register(CFG_COOK_TICKS, ticks);
        write_register(CFG_FOOD_TARGET, {2'($urandom_range(3)), target});
        write_register(CFG_WATER_OFFSET, {8'($urandom_range(255)), offset});
        write_register(CFG_HEATER_LIMIT, {2'($urandom_range(3)), hlimit});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic [1:0] op, input logic [TempW-1:0] w,
                             input logic [TempW-1:0] h, input logic [TempW-1:0] f);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        water_temp <= w;
        heater_temp <= h;
        food_temp <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(next_cooker_result(op, w, h, f));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Temperatures cluster around a threshold so that every branch is taken often.
    function automatic logic [TempW-1:0] temp_near(input logic [TempW-1:0] lim);
        int v;
        case ($urandom_range(5))
            0: v = $urandom_range(1023);
            1: v = $urandom_range(1) ? 1023 : 0;
            default: v = int'($urandom_range(4)) - 2 + int'(lim);
        endcase
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return TempW'(v);
    endfunction

    function automatic logic [TempW-1:0] any_temp();
        return TempW'($urandom_range(1023));
    endfunction

    task automatic random_run(input int max_words);
        int   r;
        logic [1:0] op;
        send_word(OP_START, any_temp(), any_temp(), any_temp());
        random_words++;
        for (int n = 0; n < max_words && heat_phase != PHASE_IDLE; n++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                op = OP_STOP;
            else if (r < 5)
                op = OP_START;
            else if (r < 30)
                op = OP_TICK;
            else
                op = OP_SAMPLE;
            if (op == OP_SAMPLE)
                send_word(op, temp_near(water_lim), temp_near(heater_lim),
                          temp_near(cfg_food_target));
            else
                send_word(op, any_temp(), any_temp(), any_temp());
            random_words++;
        end
        if (heat_phase != PHASE_IDLE)
            send_word(OP_STOP, any_temp(), any_temp(), any_temp());
    endtask

    task automatic test_directed_sequence();
        // First heating: water limit 45, heater limit 100; later ones 59 and 60.
        configure(12'd2, 10'd60, 4'd15, 10'd100);
        send_word(OP_SAMPLE, 10'd0, 10'd0, 10'd0);
        send_word(OP_TICK, 10'd1023, 10'd1023, 10'd1023);
        send_word(OP_STOP, 10'd0, 10'd0, 10'd0);
        send_word(OP_START, 10'd0, 10'd0, 10'd0);
        send_word(OP_START, 10'd1023, 10'd1023, 10'd1023);
        send_word(OP_SAMPLE, 10'd0, 10'd0, 10'd0);
        send_word(OP_TICK, 10'd0, 10'd0, 10'd0);
        send_word(OP_SAMPLE, 10'd1023, 10'd0, 10'd0);
        send_word(OP_SAMPLE, 10'd45, 10'd0, 10'd0);
        send_word(OP_SAMPLE, 10'd44, 10'd0, 10'd0);
        send_word(OP_SAMPLE, 10'd0, 10'd1023, 10'd0);
        send_word(OP_SAMPLE, 10'd59, 10'd0, 10'd0);
        send_word(OP_SAMPLE, 10'd0, 10'd0, 10'd0);
        send_word(OP_SAMPLE, 10'd0, 10'd59, 10'd0);
        send_word(OP_SAMPLE, 10'd0, 10'd0, 10'd60);
        send_word(OP_SAMPLE, 10'd0, 10'd0, 10'd59);
        send_word(OP_SAMPLE, 10'd0, 10'd0, 10'd1023);
        send_word(OP_SAMPLE, 10'd1023, 10'd1023, 10'd1023);
        send_word(OP_TICK, 10'd0, 10'd0, 10'd0);
        send_word(OP_TICK, 10'd0, 10'd0, 10'd0);
        send_word(OP_SAMPLE, 10'd0, 10'd0, 10'd1023);
        send_word(OP_START, 10'd0, 10'd0, 10'd0);
        send_word(OP_SAMPLE, 10'd1023, 10'd1023, 10'd1023);
        send_word(OP_STOP, 10'd1023, 10'd1023, 10'd1023);
        drain();
    endtask

    task automatic test_register_extremes();
        configure(12'd0, 10'd0, 4'd0, 10'd0);
        random_run(30);
        random_run(30);
        drain();
        configure(12'd4095, 10'd1023, 4'd15, 10'd1023);
        random_run(30);
        drain();
        configure(12'd0, 10'd1023, 4'd15, 10'd0);
        random_run(30);
        random_run(30);
        drain();
        // Offset larger than the target makes the first water limit saturate at zero.
        configure(12'd4095, 10'd3, 4'd15, 10'd1023);
        random_run(30);
        drain();
    endtask

    // Counts ticks past the cook time, so minutes_left walks down to one and stays there.
    task automatic test_tick_count();
        idle_pct = 0;
        configure(12'd200, 10'd10, 4'd0, 10'd1023);
        send_word(OP_START, 10'd0, 10'd0, 10'd0);
        send_word(OP_SAMPLE, 10'd0, 10'd0, 10'd1023);
        send_word(OP_SAMPLE, 10'd0, 10'd0, 10'd1023);
        repeat (240)
            send_word(OP_TICK, any_temp(), any_temp(), any_temp());
        send_word(OP_SAMPLE, 10'd0, 10'd0, 10'd1023);
        drain();
        idle_pct = 18;
    endtask

    task automatic test_output_backpressure();
        idle_pct = 0;
        configure(12'd100, 10'd80, 4'd5, 10'd300);
        pressure_req <= ~pressure_req;
        send_word(OP_START, any_temp(), any_temp(), any_temp());
        repeat (40)
            send_word(OP_SAMPLE, temp_near(water_lim), temp_near(heater_lim),
                      temp_near(cfg_food_target));
        send_word(OP_STOP, any_temp(), any_temp(), any_temp());
        drain();
        idle_pct = 18;
    endtask

    task automatic test_random_runs();
        int          runs;
        logic [TickW-1:0] ticks;
        logic [TempW-1:0] target;
        runs = 0;
        random_words = 0;
        while (random_words < RANDOM_WORDS)
        begin
            if (runs % 4 == 0)
            begin
                drain();
                // Mostly short cook times so that runs reach their normal end.
                ticks = ($urandom_range(99) < 85) ? TickW'($urandom_range(30))
                                                  : TickW'($urandom_range(4095));
                target = ($urandom_range(99) < 80) ? TempW'($urandom_range(20, 150))
                                                   : any_temp();
                configure(ticks, target, OffsetW'($urandom_range(15)),
                          $urandom_range(1) ? temp_near(target) : any_temp());
            end
            idle_pct = (random_words >= 400 && random_words < 650) ? 0 : 18;
            random_run($urandom_range(10, 80));
            // Now and then a sample or tick while idle, which the block must ignore.
            if ($urandom_range(9) == 0)
                send_word($urandom_range(1) ? OP_SAMPLE : OP_TICK,
                          any_temp(), any_temp(), any_temp());
            runs++;
        end
        drain();
        idle_pct = 18;
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_sequence();
        test_register_extremes();
        test_tick_count();
        test_output_backpressure();
        test_random_runs();
        repeat (20)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
